FILE: src/hkm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hkm_pkg: shared types and helpers for the heap k-way merge
// Field structs, heap entry type, controller states, and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package hkm_pkg;

  // Heap capacity: one entry for each run that can take part in a merge.
  localparam int MAX_RUNS = 16;
  localparam int IDX_W    = $clog2(MAX_RUNS);
  localparam int CNT_W    = $clog2(MAX_RUNS + 1);
  localparam int RUN_W    = 4;
  localparam int VAL_W    = 32;
  localparam int NR_W     = 5;

  localparam logic [NR_W-1:0] NUM_RUNS_RST = NR_W'(16);

  // Input transaction payload.
  typedef struct packed {
    logic [RUN_W-1:0]        run_index;
    logic signed [VAL_W-1:0] sample_value;
    logic                    run_exhausted;
  } in_t;

  // Result transaction payload.
  typedef struct packed {
    logic signed [VAL_W-1:0] merged_value;
    logic [RUN_W-1:0]        source_run;
    logic                    merge_done;
  } out_t;

  // One heap entry: a value and the run it came from.
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [RUN_W-1:0]        run;
  } entry_t;

  // Child index is wide enough to hold 2*idx+2 without wrapping.
  typedef logic [IDX_W+1:0] chidx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POP_RD,
    ST_REPL_RD,
    ST_EMIT_SIFT,
    ST_EMIT_IDLE,
    ST_DN_RD,
    ST_DN_CMP,
    ST_UP_RD,
    ST_UP_CMP
  } state_t;

  // Which addresses the two heap read ports look at.
  typedef enum logic [1:0] {
    RD_ROOT,
    RD_CHILD,
    RD_PARENT
  } rd_mode_t;

  // What goes into the staged result.
  typedef enum logic [1:0] {
    RES_NONE,
    RES_ROOT,
    RES_CUR,
    RES_DONE
  } res_sel_t;

  typedef struct packed {
    logic     take_item;
    logic     load_inc;
    logic     load_clr;
    logic     ins_start;
    logic     pop_start;
    logic     repl_start;
    logic     wr_cur;
    logic     dn_step;
    logic     up_step;
    logic     out_load;
    rd_mode_t rd_mode;
    res_sel_t res_sel;
  } cmd_t;

  typedef struct packed {
    logic in_exh;
    logic loading;
    logic empty;
    logic full;
    logic take_root;
    logic up_less;
    logic dn_move;
    logic idx_zero;
    logic out_free;
  } sts_t;

  // Signed value order; equal values go to the lower run.
  function automatic logic key_less(entry_t a, entry_t b);
    logic lt;
    if (a.value != b.value) begin
      lt = (a.value < b.value);
    end else begin
      lt = (a.run < b.run);
    end
    return lt;
  endfunction

endpackage
`default_nettype wire

FILE: src/hkm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hkm_ctrl: sequencer for the heap k-way merge
// Steps each transaction through root read, result staging and the sift
// loops, issuing commands to the datapath and reading back its status.
// ----------------------------------------------------------------------------
module hkm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire hkm_pkg::sts_t sts,
  output hkm_pkg::cmd_t      cmd
);

  hkm_pkg::state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hkm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hkm_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (sts.loading) begin
            if (!sts.in_exh && !sts.full) begin
              state_nxt = hkm_pkg::ST_UP_RD;
            end
          end else if (sts.in_exh && sts.empty) begin
            state_nxt = hkm_pkg::ST_EMIT_IDLE;
          end else if (sts.in_exh) begin
            state_nxt = hkm_pkg::ST_POP_RD;
          end else begin
            state_nxt = hkm_pkg::ST_REPL_RD;
          end
        end
      end
      hkm_pkg::ST_POP_RD: state_nxt = hkm_pkg::ST_EMIT_SIFT;
      hkm_pkg::ST_REPL_RD: begin
        state_nxt = sts.take_root ? hkm_pkg::ST_EMIT_SIFT : hkm_pkg::ST_EMIT_IDLE;
      end
      hkm_pkg::ST_EMIT_SIFT: begin
        if (sts.out_free) begin
          state_nxt = hkm_pkg::ST_DN_RD;
        end
      end
      hkm_pkg::ST_EMIT_IDLE: begin
        if (sts.out_free) begin
          state_nxt = hkm_pkg::ST_IDLE;
        end
      end
      hkm_pkg::ST_DN_RD: state_nxt = hkm_pkg::ST_DN_CMP;
      hkm_pkg::ST_DN_CMP: begin
        state_nxt = sts.dn_move ? hkm_pkg::ST_DN_RD : hkm_pkg::ST_IDLE;
      end
      hkm_pkg::ST_UP_RD: begin
        state_nxt = sts.idx_zero ? hkm_pkg::ST_IDLE : hkm_pkg::ST_UP_CMP;
      end
      hkm_pkg::ST_UP_CMP: begin
        state_nxt = sts.up_less ? hkm_pkg::ST_UP_RD : hkm_pkg::ST_IDLE;
      end
      default: state_nxt = hkm_pkg::ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd         = '0;
    cmd.rd_mode = hkm_pkg::RD_ROOT;
    cmd.res_sel = hkm_pkg::RES_NONE;
    in_ready    = 1'b0;
    case (state_r)
      hkm_pkg::ST_IDLE: begin
        // Root and last entry are read every idle cycle, ready for a pop.
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_item = 1'b1;
          if (sts.loading) begin
            cmd.load_inc  = 1'b1;
            cmd.ins_start = !sts.in_exh && !sts.full;
          end else if (sts.in_exh && sts.empty) begin
            cmd.res_sel  = hkm_pkg::RES_DONE;
            cmd.load_clr = 1'b1;
          end
        end
      end
      hkm_pkg::ST_POP_RD: begin
        cmd.res_sel   = hkm_pkg::RES_ROOT;
        cmd.pop_start = 1'b1;
      end
      hkm_pkg::ST_REPL_RD: begin
        if (sts.take_root) begin
          cmd.res_sel    = hkm_pkg::RES_ROOT;
          cmd.repl_start = 1'b1;
        end else begin
          cmd.res_sel = hkm_pkg::RES_CUR;
        end
      end
      hkm_pkg::ST_EMIT_SIFT, hkm_pkg::ST_EMIT_IDLE: begin
        cmd.out_load = sts.out_free;
      end
      hkm_pkg::ST_DN_RD: begin
        cmd.rd_mode = hkm_pkg::RD_CHILD;
      end
      hkm_pkg::ST_DN_CMP: begin
        cmd.dn_step = sts.dn_move;
        cmd.wr_cur  = !sts.dn_move;
      end
      hkm_pkg::ST_UP_RD: begin
        cmd.rd_mode = hkm_pkg::RD_PARENT;
        cmd.wr_cur  = sts.idx_zero;
      end
      hkm_pkg::ST_UP_CMP: begin
        cmd.up_step = sts.up_less;
        cmd.wr_cur  = !sts.up_less;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: src/hkm_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hkm_dp: datapath for the heap k-way merge
// Heap memory with two registered read ports, the moving entry and its
// position, counters, the run-count register and the result register.
// ----------------------------------------------------------------------------
module hkm_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire hkm_pkg::in_t                  in_data,
  input  wire logic                          cfg_wr_en,
  input  wire logic [hkm_pkg::NR_W-1:0]      cfg_wr_data,
  input  wire hkm_pkg::cmd_t                 cmd,
  output hkm_pkg::sts_t                      sts,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output hkm_pkg::out_t                      out_data
);

  hkm_pkg::entry_t mem [hkm_pkg::MAX_RUNS];
  hkm_pkg::entry_t rd_a_r, rd_b_r;
  hkm_pkg::entry_t cur_r, cur_nxt;
  hkm_pkg::entry_t wr_data, dn_child;
  hkm_pkg::out_t   res_r, res_nxt;
  hkm_pkg::out_t   out_data_r;

  logic [hkm_pkg::NR_W-1:0]  num_runs_r;
  logic [hkm_pkg::CNT_W-1:0] count_r, count_nxt, cnt_m1, nr_eff;
  logic [hkm_pkg::CNT_W-1:0] heads_r, heads_nxt;
  logic [hkm_pkg::IDX_W-1:0] idx_r, idx_nxt, parent, dn_m, rd_a_addr, rd_b_addr;
  logic                      out_valid_r, out_valid_nxt, wr_en;
  logic                      l_lt, r_lt;
  hkm_pkg::chidx_t           child_l, child_r, count_ext;
  hkm_pkg::entry_t           best_lr;

  // Effective run count: zero acts as one, oversize acts as full capacity.
  always_comb begin
    if (num_runs_r == '0) begin
      nr_eff = hkm_pkg::CNT_W'(1);
    end else if (int'(num_runs_r) > hkm_pkg::MAX_RUNS) begin
      nr_eff = hkm_pkg::CNT_W'(hkm_pkg::MAX_RUNS);
    end else begin
      nr_eff = hkm_pkg::CNT_W'(num_runs_r);
    end
  end

  // Heap index arithmetic.
  assign cnt_m1    = count_r - hkm_pkg::CNT_W'(1);
  assign parent    = (idx_r - hkm_pkg::IDX_W'(1)) >> 1;
  assign child_l   = {1'b0, idx_r, 1'b1};
  assign child_r   = child_l + hkm_pkg::chidx_t'(1);
  assign count_ext = hkm_pkg::chidx_t'(count_r);

  // Read address selection.
  always_comb begin
    case (cmd.rd_mode)
      hkm_pkg::RD_CHILD: begin
        rd_a_addr = child_l[hkm_pkg::IDX_W-1:0];
        rd_b_addr = child_r[hkm_pkg::IDX_W-1:0];
      end
      hkm_pkg::RD_PARENT: begin
        rd_a_addr = parent;
        rd_b_addr = parent;
      end
      default: begin
        rd_a_addr = '0;
        rd_b_addr = cnt_m1[hkm_pkg::IDX_W-1:0];
      end
    endcase
  end

  // Sift-down choice: the smaller of the moving entry and its live children.
  always_comb begin
    l_lt     = (child_l < count_ext) && hkm_pkg::key_less(rd_a_r, cur_r);
    best_lr  = l_lt ? rd_a_r : cur_r;
    r_lt     = (child_r < count_ext) && hkm_pkg::key_less(rd_b_r, best_lr);
    dn_child = r_lt ? rd_b_r : rd_a_r;
    dn_m     = r_lt ? child_r[hkm_pkg::IDX_W-1:0] : child_l[hkm_pkg::IDX_W-1:0];
  end

  // Heap write: the moving entry settles, or a child or parent moves into the hole.
  always_comb begin
    wr_en = cmd.wr_cur || cmd.dn_step || cmd.up_step;
    if (cmd.wr_cur) begin
      wr_data = cur_r;
    end else if (cmd.dn_step) begin
      wr_data = dn_child;
    end else begin
      wr_data = rd_a_r;
    end
  end

  // Heap memory, at most one write and two registered reads each cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx_r] <= wr_data;
    end
    rd_a_r <= mem[rd_a_addr];
    rd_b_r <= mem[rd_b_addr];
  end

  // Next values of the working registers.
  always_comb begin
    cur_nxt   = cur_r;
    idx_nxt   = idx_r;
    count_nxt = count_r;
    heads_nxt = heads_r;
    if (cmd.take_item) begin
      cur_nxt = '{value: in_data.sample_value, run: in_data.run_index};
    end
    if (cmd.pop_start) begin
      cur_nxt   = rd_b_r;
      count_nxt = cnt_m1;
      idx_nxt   = '0;
    end
    if (cmd.repl_start) begin
      idx_nxt = '0;
    end
    if (cmd.ins_start) begin
      idx_nxt   = count_r[hkm_pkg::IDX_W-1:0];
      count_nxt = count_r + hkm_pkg::CNT_W'(1);
    end
    if (cmd.dn_step) begin
      idx_nxt = dn_m;
    end
    if (cmd.up_step) begin
      idx_nxt = parent;
    end
    if (cmd.load_inc) begin
      heads_nxt = heads_r + hkm_pkg::CNT_W'(1);
    end
    if (cmd.load_clr) begin
      heads_nxt = '0;
    end
  end

  // Staged result.
  always_comb begin
    res_nxt = res_r;
    case (cmd.res_sel)
      hkm_pkg::RES_ROOT: res_nxt = '{merged_value: rd_a_r.value,
                                     source_run:   rd_a_r.run,
                                     merge_done:   1'b0};
      hkm_pkg::RES_CUR:  res_nxt = '{merged_value: cur_r.value,
                                     source_run:   cur_r.run,
                                     merge_done:   1'b0};
      hkm_pkg::RES_DONE: res_nxt = '{merged_value: '0,
                                     source_run:   '0,
                                     merge_done:   1'b1};
      default:           res_nxt = res_r;
    endcase
  end

  // Output register valid flag.
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_runs_r  <= hkm_pkg::NUM_RUNS_RST;
      count_r     <= '0;
      heads_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        num_runs_r <= cfg_wr_data;
      end
      count_r     <= count_nxt;
      heads_r     <= heads_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    idx_r <= idx_nxt;
    res_r <= res_nxt;
    if (cmd.out_load) begin
      out_data_r <= res_r;
    end
  end

  // Status back to the controller.
  always_comb begin
    sts.in_exh    = in_data.run_exhausted;
    sts.loading   = (heads_r < nr_eff);
    sts.empty     = (count_r == '0);
    sts.full      = (count_r >= hkm_pkg::CNT_W'(hkm_pkg::MAX_RUNS));
    sts.take_root = (count_r != '0) && hkm_pkg::key_less(rd_a_r, cur_r);
    sts.up_less   = hkm_pkg::key_less(cur_r, rd_a_r);
    sts.dn_move   = l_lt || r_lt;
    sts.idx_zero  = (idx_r == '0);
    sts.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

FILE: src/heap_kway_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// heap_kway_merge: k-way merge of sorted signed runs through a min-heap
// Top level joining the sequencer and the heap datapath.
// ----------------------------------------------------------------------------
// Usage. The input channel (in_valid/in_ready/in_data) carries one transaction
// per run value or run-exhausted mark. The first num_runs transactions of a
// merge load the run heads and give no result. Every later transaction gives
// one result on the output channel (out_valid/out_ready/out_data): the
// smallest value held and the run it came from, which is the run to refill
// next. An exhausted mark that finds the heap empty gives a result with
// merge_done set and rearms the block for a new merge.
// One transaction is handled at a time: in_ready is high only while idle. An
// exhausted head during loading is only counted; an inserted head climbs the
// heap level by level until it settles. A merge step stages its result, waits
// for the output register to free, then sifts the moving entry down level by
// level until it settles; a value that passes straight through, and the
// end-of-merge marker, skip the sift. Each sift level reads the heap memory
// through its registered read ports before comparing.
// The result sits in an output register, so a new transaction is taken while
// the previous result waits; if the receiver stalls, the next result waits in
// its staging register until the output register frees.
// Reset (synchronous, rst_n low) empties the heap, clears the load count and
// sets num_runs to 16. cfg_wr_en writes num_runs from cfg_wr_data.
// ----------------------------------------------------------------------------
module heap_kway_merge (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire hkm_pkg::in_t             in_data,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output hkm_pkg::out_t                 out_data,
  input  wire logic                     cfg_wr_en,
  input  wire logic [hkm_pkg::NR_W-1:0] cfg_wr_data
);

  hkm_pkg::cmd_t cmd;
  hkm_pkg::sts_t sts;

  // Sequencer.
  hkm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Heap datapath.
  hkm_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule
`default_nettype wire

FILE: src/hkm_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hkm_checker: port-level checks for the heap k-way merge
// Watches the top-level ports and flags behaviour the block must never show.
// ----------------------------------------------------------------------------
module hkm_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire hkm_pkg::out_t out_data
);

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result transaction holds its payload.
  a_stall_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // An end-of-merge marker carries zero value and run fields.
  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.merge_done |->
      out_data.merged_value == '0 && out_data.source_run == '0)
    else $error("merge_done result with non-zero fields");

  // A new result is only presented while the block is busy with a transaction.
  a_result_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while the block was idle");

endmodule

bind heap_kway_merge hkm_checker u_hkm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
